// File: design/bfie_pkg.sv
// ----------------------------------------------------------------------------
// bfie_pkg
// Shared types and constants of the Brainfuck instruction executor: sequencer
// states, item actions, error codes and instruction characters.
// ----------------------------------------------------------------------------
package bfie_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK
  } state_t;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_STEP    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_PTR_HIGH = 3'd1;
  localparam logic [2:0] ERR_PTR_LOW  = 3'd2;
  localparam logic [2:0] ERR_NO_CLOSE = 3'd3;
  localparam logic [2:0] ERR_NO_OPEN  = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd5;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

endpackage

// File: design/brainfuck_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// brainfuck_instruction_executor_core
// Brainfuck processor with a program memory and a tape memory, each a
// synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its one result is
// shown for a single cycle with out_strobe high; the receiver cannot stall, so
// it must take every result in that cycle. Load items and unused actions keep
// busy low and strobe their result in the next cycle. A step holds busy in
// the execute state, which uses the registered reads of both memories, and
// strobes its result from a register; no item is taken until it is through.
// A taken bracket adds a scan that reads each program byte in ST_SCAN_RD and
// checks the depth counter in ST_SCAN_CHK. Restart runs a clearing pass over
// the tape memory, one entry a cycle, and strobes once the last entry is
// cleared; the same pass follows reset, with busy high. Configuration writes
// are always ready.
module brainfuck_instruction_executor_core
  import bfie_pkg::*;
#(
  parameter int TAPE_DEPTH    = 1024,
  parameter int PROGRAM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_program_char,
  input  logic [7:0]  in_input_byte,
  input  logic        in_input_available,
  output logic        out_strobe,
  output logic        out_out_valid,
  output logic [7:0]  out_out_byte,
  output logic        out_input_taken,
  output logic        out_halted,
  output logic [2:0]  out_error_code,
  output logic        out_program_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_program_length
);

  localparam int TW = $clog2(TAPE_DEPTH);
  localparam int PW = $clog2(PROGRAM_DEPTH);
  localparam int IW = PW + 1;
  localparam int LW = (IW > 13) ? IW : 13;
  localparam logic [LW-1:0] PROG_DEPTH_L = LW'(PROGRAM_DEPTH);
  localparam logic [TW-1:0] TAPE_LAST    = TW'(TAPE_DEPTH - 1);

  logic [7:0] prog_mem [PROGRAM_DEPTH];
  logic [7:0] tape_mem [TAPE_DEPTH];

  state_t        state_r, state_nxt;
  logic [12:0]   len_r;
  logic [TW-1:0] dp_r, dp_nxt;
  logic [IW-1:0] ip_r, ip_nxt;
  logic          halt_r, halt_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] depth_r, depth_nxt;
  logic          fwd_r, fwd_nxt;
  logic [TW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_resp_r, clr_resp_nxt;
  logic          strobe_r, strobe_nxt;
  logic          emit_r, emit_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          taken_r, taken_nxt;
  logic [7:0]    in_byte_r, in_byte_nxt;
  logic          in_avail_r, in_avail_nxt;

  logic [7:0]    prog_rdata_r, tape_rdata_r;
  logic [PW-1:0] prog_raddr;
  logic          tape_we;
  logic [TW-1:0] tape_waddr;
  logic [7:0]    tape_wdata;

  logic [LW-1:0] eff_len;
  logic          done;
  logic          accept;
  logic          load_ok;

  logic          ex_nop, ex_fault, ex_scan, ex_wr, ex_emit, ex_taken;
  logic [2:0]    ex_code;
  logic [TW-1:0] ex_dp;
  logic [7:0]    ex_wdata;

  logic          sc_past_end, sc_hit, sc_at_zero;
  logic [IW-1:0] sc_depth;

  assign eff_len = (LW'(len_r) < PROG_DEPTH_L) ? LW'(len_r) : PROG_DEPTH_L;
  assign done    = LW'(ip_r) >= eff_len;
  assign busy    = state_r != ST_IDLE;
  assign accept  = start && !busy;
  assign load_ok = LW'(in_address) < PROG_DEPTH_L;

  assign cfg_ready        = 1'b1;
  assign out_strobe       = strobe_r;
  assign out_out_valid    = emit_r;
  assign out_out_byte     = obyte_r;
  assign out_input_taken  = taken_r;
  assign out_halted       = halt_r;
  assign out_error_code   = err_r;
  assign out_program_done = done;

  always_ff @(posedge clk) begin
    if (accept && in_action == ACT_LOAD && load_ok) begin
      prog_mem[PW'(in_address)] <= in_program_char;
    end
    prog_rdata_r <= prog_mem[prog_raddr];
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    tape_rdata_r <= tape_mem[dp_r];
  end

  always_comb begin
    ex_nop   = halt_r || done;
    ex_fault = 1'b0;
    ex_code  = ERR_NONE;
    ex_scan  = 1'b0;
    ex_wr    = 1'b0;
    ex_emit  = 1'b0;
    ex_taken = 1'b0;
    ex_dp    = dp_r;
    ex_wdata = tape_rdata_r;
    if (!ex_nop) begin
      case (prog_rdata_r)
        CH_RIGHT: begin
          if (dp_r == TAPE_LAST) begin
            ex_fault = 1'b1;
            ex_code  = ERR_PTR_HIGH;
          end else begin
            ex_dp = dp_r + 1'b1;
          end
        end
        CH_LEFT: begin
          if (dp_r == '0) begin
            ex_fault = 1'b1;
            ex_code  = ERR_PTR_LOW;
          end else begin
            ex_dp = dp_r - 1'b1;
          end
        end
        CH_INC: begin
          ex_wr    = 1'b1;
          ex_wdata = tape_rdata_r + 8'd1;
        end
        CH_DEC: begin
          ex_wr    = 1'b1;
          ex_wdata = tape_rdata_r - 8'd1;
        end
        CH_OUT: begin
          ex_emit = 1'b1;
        end
        CH_IN: begin
          if (in_avail_r) begin
            ex_wr    = 1'b1;
            ex_wdata = in_byte_r;
            ex_taken = 1'b1;
          end
        end
        CH_OPEN: begin
          ex_scan = tape_rdata_r == 8'd0;
        end
        CH_CLOSE: begin
          if (tape_rdata_r != 8'd0) begin
            if (ip_r == '0) begin
              ex_fault = 1'b1;
              ex_code  = ERR_NO_OPEN;
            end else begin
              ex_scan = 1'b1;
            end
          end
        end
        default: begin
          ex_fault = 1'b1;
          ex_code  = ERR_UNKNOWN;
        end
      endcase
    end
  end

  always_comb begin
    sc_past_end = fwd_r && (LW'(j_r) >= eff_len);
    sc_at_zero  = j_r == '0;
    sc_hit      = 1'b0;
    sc_depth    = depth_r;
    if (prog_rdata_r == (fwd_r ? CH_OPEN : CH_CLOSE)) begin
      sc_depth = depth_r + 1'b1;
    end else if (prog_rdata_r == (fwd_r ? CH_CLOSE : CH_OPEN)) begin
      sc_depth = depth_r - 1'b1;
      sc_hit   = depth_r == IW'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == TAPE_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_STEP:    state_nxt = ST_EXEC;
            ACT_RESTART: state_nxt = ST_CLEAR;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        state_nxt = ex_scan ? ST_SCAN_RD : ST_IDLE;
      end
      ST_SCAN_RD: begin
        state_nxt = sc_past_end ? ST_IDLE : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (sc_hit || (!fwd_r && sc_at_zero)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_nxt       = dp_r;
    ip_nxt       = ip_r;
    halt_nxt     = halt_r;
    err_nxt      = err_r;
    j_nxt        = j_r;
    depth_nxt    = depth_r;
    fwd_nxt      = fwd_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_resp_nxt = clr_resp_r;
    strobe_nxt   = 1'b0;
    emit_nxt     = 1'b0;
    obyte_nxt    = 8'd0;
    taken_nxt    = 1'b0;
    in_byte_nxt  = in_byte_r;
    in_avail_nxt = in_avail_r;
    tape_we      = 1'b0;
    tape_waddr   = dp_r;
    tape_wdata   = ex_wdata;
    prog_raddr   = ip_r[PW-1:0];
    case (state_r)
      ST_CLEAR: begin
        tape_we     = 1'b1;
        tape_waddr  = clr_cnt_r;
        tape_wdata  = 8'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == TAPE_LAST) begin
          strobe_nxt   = clr_resp_r;
          clr_resp_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          in_byte_nxt  = in_input_byte;
          in_avail_nxt = in_input_available;
          case (in_action)
            ACT_STEP: begin
            end
            ACT_RESTART: begin
              dp_nxt       = '0;
              ip_nxt       = '0;
              halt_nxt     = 1'b0;
              err_nxt      = ERR_NONE;
              clr_cnt_nxt  = '0;
              clr_resp_nxt = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_EXEC: begin
        tape_we = ex_wr;
        dp_nxt  = ex_dp;
        if (ex_fault) begin
          halt_nxt = 1'b1;
          err_nxt  = ex_code;
        end else if (!ex_nop && !ex_scan) begin
          ip_nxt = ip_r + 1'b1;
        end
        fwd_nxt   = prog_rdata_r == CH_OPEN;
        depth_nxt = IW'(1);
        j_nxt     = (prog_rdata_r == CH_OPEN) ? ip_r + 1'b1 : ip_r - 1'b1;
        if (!ex_scan) begin
          strobe_nxt = 1'b1;
          emit_nxt   = ex_emit;
          obyte_nxt  = ex_emit ? tape_rdata_r : 8'd0;
          taken_nxt  = ex_taken;
        end
      end
      ST_SCAN_RD: begin
        prog_raddr = j_r[PW-1:0];
        if (sc_past_end) begin
          halt_nxt   = 1'b1;
          err_nxt    = ERR_NO_CLOSE;
          strobe_nxt = 1'b1;
        end
      end
      ST_SCAN_CHK: begin
        depth_nxt = sc_depth;
        if (sc_hit) begin
          ip_nxt     = j_r + 1'b1;
          strobe_nxt = 1'b1;
        end else if (!fwd_r && sc_at_zero) begin
          halt_nxt   = 1'b1;
          err_nxt    = ERR_NO_OPEN;
          strobe_nxt = 1'b1;
        end else begin
          j_nxt = fwd_r ? j_r + 1'b1 : j_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      len_r      <= '0;
      dp_r       <= '0;
      ip_r       <= '0;
      halt_r     <= 1'b0;
      err_r      <= ERR_NONE;
      clr_cnt_r  <= '0;
      clr_resp_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      dp_r       <= dp_nxt;
      ip_r       <= ip_nxt;
      halt_r     <= halt_nxt;
      err_r      <= err_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      clr_resp_r <= clr_resp_nxt;
      strobe_r   <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_program_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    depth_r    <= depth_nxt;
    fwd_r      <= fwd_nxt;
    emit_r     <= emit_nxt;
    obyte_r    <= obyte_nxt;
    taken_r    <= taken_nxt;
    in_byte_r  <= in_byte_nxt;
    in_avail_r <= in_avail_nxt;
  end

endmodule

// File: verif/tb_brainfuck_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// tb_brainfuck_instruction_executor_core
// Self-checking testbench of the Brainfuck instruction executor. A shadow
// machine in the testbench tracks program memory, tape, pointers and the
// fault latch, and computes the status that each item transfer must produce.
// Directed programs cover every instruction, the bracket scans and the faults
// for a low pointer and a missing close. Random bracket-balanced programs
// with noise then run under three sender idle mixes, with the program length
// register changed between them.
// ----------------------------------------------------------------------------
module tb_brainfuck_instruction_executor_core
  import bfie_pkg::*;
();

  localparam int TAPE_CELLS    = 1024;
  localparam int PROGRAM_CELLS = 4096;
  localparam int STALL_LIMIT   = 30000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic       emitted;
    logic [7:0] out_byte;
    logic       taken;
    logic       halted;
    logic [2:0] error;
    logic       done;
  } bf_status_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [11:0] in_address;
  logic [7:0]  in_program_char;
  logic [7:0]  in_input_byte;
  logic        in_input_available;
  logic        out_strobe;
  logic        out_out_valid;
  logic [7:0]  out_out_byte;
  logic        out_input_taken;
  logic        out_halted;
  logic [2:0]  out_error_code;
  logic        out_program_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_program_length;

  logic [7:0]  program_mem    [PROGRAM_CELLS];
  bit          program_loaded [PROGRAM_CELLS];
  logic [7:0]  tape_mem       [TAPE_CELLS];
  logic [9:0]  data_ptr;
  logic [12:0] instr_ptr;
  logic        halt_latched;
  logic [2:0]  error_latched;
  logic [12:0] length_reg;

  bf_status_t pending_status [16];
  int         pushed_total = 0;
  int         popped_total = 0;
  int         mismatch_count;
  int         results_checked;
  int         working_items;
  int         sender_idle_pct;
  int         stall_cycles;
  int         action_count [4];
  bit         fault_seen [8];

  brainfuck_instruction_executor_core #(
    .TAPE_DEPTH    (TAPE_CELLS),
    .PROGRAM_DEPTH (PROGRAM_CELLS)
  ) i_dut (
    .clk,
    .rst_n,
    .start,
    .busy,
    .in_action,
    .in_address,
    .in_program_char,
    .in_input_byte,
    .in_input_available,
    .out_strobe,
    .out_out_valid,
    .out_out_byte,
    .out_input_taken,
    .out_halted,
    .out_error_code,
    .out_program_done,
    .cfg_valid,
    .cfg_ready,
    .cfg_program_length
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int run_length();
    return (length_reg < PROGRAM_CELLS) ? int'(length_reg) : PROGRAM_CELLS;
  endfunction

  // Finds the partner bracket with a depth counter; clean drops if the scan
  // touched a program byte that was never loaded.
  function automatic bit seek_bracket(input int from, input bit forward,
                                      output int pos, output bit clean);
    int depth;
    int j;
    logic [7:0] ch;
    depth = 1;
    clean = 1'b1;
    pos = from;
    j = forward ? from + 1 : from - 1;
    while (forward ? (j < run_length()) : (j >= 0)) begin
      if (!program_loaded[12'(j)]) clean = 1'b0;
      ch = program_mem[12'(j)];
      if (ch == (forward ? CH_OPEN : CH_CLOSE)) begin
        depth++;
      end else if (ch == (forward ? CH_CLOSE : CH_OPEN)) begin
        depth--;
        if (depth == 0) begin
          pos = j;
          return 1'b1;
        end
      end
      j = forward ? j + 1 : j - 1;
    end
    return 1'b0;
  endfunction

  function automatic bit step_is_safe();
    int pos;
    bit clean;
    if (halt_latched || instr_ptr >= run_length()) return 1'b1;
    if (!program_loaded[instr_ptr[11:0]]) return 1'b0;
    clean = 1'b1;
    if (program_mem[instr_ptr[11:0]] == CH_OPEN && tape_mem[data_ptr] == 8'd0)
      void'(seek_bracket(instr_ptr, 1'b1, pos, clean));
    else if (program_mem[instr_ptr[11:0]] == CH_CLOSE && tape_mem[data_ptr] != 8'd0)
      void'(seek_bracket(instr_ptr, 1'b0, pos, clean));
    return clean;
  endfunction

  function automatic bf_status_t apply_bf_item(input logic [1:0] action,
                                               input logic [11:0] addr,
                                               input logic [7:0] ch,
                                               input logic [7:0] in_byte,
                                               input logic in_avail);
    bf_status_t st;
    int pos;
    bit clean;
    logic [2:0] fault;
    logic [12:0] next_ip;
    st = '0;
    fault = ERR_NONE;
    case (action)
      ACT_LOAD: begin
        program_mem[addr] = ch;
        program_loaded[addr] = 1'b1;
      end
      ACT_RESTART: begin
        foreach (tape_mem[k]) tape_mem[k] = 8'd0;
        data_ptr = '0;
        instr_ptr = '0;
        halt_latched = 1'b0;
        error_latched = ERR_NONE;
      end
      ACT_STEP: begin
        if (!halt_latched && instr_ptr < run_length()) begin
          next_ip = instr_ptr;
          case (program_mem[instr_ptr[11:0]])
            CH_RIGHT: begin
              if (data_ptr == TAPE_CELLS - 1) fault = ERR_PTR_HIGH;
              else data_ptr = data_ptr + 1'b1;
            end
            CH_LEFT: begin
              if (data_ptr == 0) fault = ERR_PTR_LOW;
              else data_ptr = data_ptr - 1'b1;
            end
            CH_INC: tape_mem[data_ptr] = tape_mem[data_ptr] + 8'd1;
            CH_DEC: tape_mem[data_ptr] = tape_mem[data_ptr] - 8'd1;
            CH_OUT: begin
              st.emitted = 1'b1;
              st.out_byte = tape_mem[data_ptr];
            end
            CH_IN: begin
              if (in_avail) begin
                tape_mem[data_ptr] = in_byte;
                st.taken = 1'b1;
              end
            end
            CH_OPEN: begin
              if (tape_mem[data_ptr] == 8'd0) begin
                if (seek_bracket(instr_ptr, 1'b1, pos, clean)) next_ip = 13'(pos);
                else fault = ERR_NO_CLOSE;
              end
            end
            CH_CLOSE: begin
              if (tape_mem[data_ptr] != 8'd0) begin
                if (seek_bracket(instr_ptr, 1'b0, pos, clean)) next_ip = 13'(pos);
                else fault = ERR_NO_OPEN;
              end
            end
            default: fault = ERR_UNKNOWN;
          endcase
          if (fault != ERR_NONE) begin
            halt_latched = 1'b1;
            error_latched = fault;
            fault_seen[fault] = 1'b1;
          end else begin
            instr_ptr = next_ip + 13'd1;
          end
        end
      end
      default: ;
    endcase
    st.halted = halt_latched;
    st.error = error_latched;
    st.done = (instr_ptr >= run_length());
    return st;
  endfunction

  task automatic post_expected(input bf_status_t st);
    pending_status[4'(pushed_total)] = st;
    pushed_total++;
  endtask

  task automatic issue_item(input logic [1:0] action, input logic [11:0] addr,
                            input logic [7:0] ch, input logic [7:0] in_byte,
                            input logic in_avail);
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start = 1'b1;
    in_action = action;
    in_address = addr;
    in_program_char = ch;
    in_input_byte = in_byte;
    in_input_available = in_avail;
    do @(posedge clk); while (busy);
    if (action != ACT_UNUSED &&
        !(action == ACT_STEP && (halt_latched || instr_ptr >= run_length())))
      working_items++;
    action_count[action]++;
    post_expected(apply_bf_item(action, addr, ch, in_byte, in_avail));
  endtask

  task automatic issue_random(input logic [1:0] action);
    issue_item(action, 12'($urandom_range(4095)), 8'($urandom_range(255)),
               8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic load_text(input string text);
    int i;
    for (i = 0; i < text.len(); i++)
      issue_item(ACT_LOAD, 12'(i), text[i], 8'($urandom_range(255)),
                 1'($urandom_range(1)));
  endtask

  task automatic wait_for_quiet();
    @(negedge clk);
    start = 1'b0;
    while (pushed_total != popped_total) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_program_length(input logic [12:0] new_length);
    wait_for_quiet();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_program_length = new_length;
    do @(posedge clk); while (!cfg_ready);
    length_reg = new_length;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    bf_status_t want;
    if (rst_n && out_strobe) begin
      if (pushed_total == popped_total) begin
        $display("%0t: result transfer with no item outstanding", $time);
        mismatch_count++;
      end else begin
        want = pending_status[4'(popped_total)];
        popped_total++;
        compare_field("out_valid", want.emitted, out_out_valid);
        compare_field("out_byte", want.out_byte, out_out_byte);
        compare_field("input_taken", want.taken, out_input_taken);
        compare_field("halted", want.halted, out_halted);
        compare_field("error_code", want.error, out_error_code);
        compare_field("program_done", want.done, out_program_done);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic test_idle_status();
    issue_random(ACT_UNUSED);
    issue_random(ACT_STEP);
    set_program_length(13'd0);
    issue_random(ACT_STEP);
  endtask

  task automatic test_operations();
    int i;
    set_program_length(13'h1FFF);
    load_text("+.--.,,.><<");
    issue_item(ACT_LOAD, 12'hFFF, 8'hFF, 8'h00, 1'b0);
    for (i = 0; i < 12; i++)
      issue_item(ACT_STEP, 12'($urandom_range(4095)), 8'($urandom_range(255)),
                 (i == 5) ? 8'hFF : 8'h00, i == 5);
    issue_random(ACT_RESTART);
  endtask

  task automatic test_brackets();
    int i;
    set_program_length(13'd8);
    load_text("[]++[-][");
    for (i = 0; i < 11; i++) issue_random(ACT_STEP);
    issue_random(ACT_RESTART);
  endtask

  task automatic run_random_program();
    logic [7:0] text [128];
    logic [7:0] pick;
    logic [12:0] new_length;
    int text_len;
    int count;
    int opens;
    int roll;
    int budget;
    int i;
    text_len = 0;
    count = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(20, 1);
    opens = 0;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        pick = CH_INC;
      end else if (roll < 40) begin
        pick = CH_DEC;
      end else if (roll < 52) begin
        pick = CH_RIGHT;
      end else if (roll < 60) begin
        pick = CH_LEFT;
      end else if (roll < 68) begin
        pick = CH_OUT;
      end else if (roll < 75) begin
        pick = CH_IN;
      end else if (roll < 86) begin
        pick = CH_OPEN;
        opens++;
      end else if (roll < 96) begin
        if (opens > 0) begin
          pick = CH_CLOSE;
          opens--;
        end else begin
          pick = CH_INC;
        end
      end else if (roll < 98) begin
        pick = 8'($urandom_range(255));
      end else begin
        pick = CH_CLOSE;
      end
      text[7'(text_len)] = pick;
      text_len++;
    end
    while (opens > 0 && $urandom_range(9) != 0) begin
      text[7'(text_len)] = CH_CLOSE;
      text_len++;
      opens--;
    end

    roll = $urandom_range(99);
    if (roll < 70) new_length = 13'(text_len);
    else if (roll < 76) new_length = 13'd0;
    else if (roll < 82) new_length = 13'h1FFF;
    else if (roll < 88) new_length = 13'(PROGRAM_CELLS);
    else if (roll < 94) new_length = 13'($urandom_range(text_len, 0));
    else new_length = 13'(text_len + $urandom_range(200, 1));
    set_program_length(new_length);

    for (i = 0; i < text_len; i++)
      issue_item(ACT_LOAD, 12'(i), text[7'(i)], 8'($urandom_range(255)),
                 1'($urandom_range(1)));
    issue_random(ACT_RESTART);

    budget = $urandom_range(80, 10);
    while (budget > 0) begin
      budget--;
      roll = $urandom_range(99);
      if (roll < 3) begin
        issue_random(ACT_RESTART);
      end else if (roll < 6) begin
        issue_random(ACT_UNUSED);
      end else if (roll < 10) begin
        issue_random(ACT_LOAD);
      end else if (halt_latched || instr_ptr >= run_length()) begin
        issue_random(ACT_STEP);
        budget = 0;
      end else if (!step_is_safe()) begin
        budget = 0;
      end else begin
        issue_random(ACT_STEP);
      end
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int item_total);
    int stop_at;
    sender_idle_pct = idle_pct;
    stop_at = working_items + item_total;
    while (working_items < stop_at) run_random_program();
  endtask

  initial begin
    int faults_hit;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_LOAD;
    in_address = '0;
    in_program_char = '0;
    in_input_byte = '0;
    in_input_available = 1'b0;
    cfg_valid = 1'b0;
    cfg_program_length = '0;
    foreach (program_mem[k]) program_mem[k] = 8'd0;
    foreach (program_loaded[k]) program_loaded[k] = 1'b0;
    foreach (tape_mem[k]) tape_mem[k] = 8'd0;
    data_ptr = '0;
    instr_ptr = '0;
    halt_latched = 1'b0;
    error_latched = ERR_NONE;
    length_reg = '0;
    mismatch_count = 0;
    results_checked = 0;
    working_items = 0;
    stall_cycles = 0;
    sender_idle_pct = 18;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_status();
    test_operations();
    test_brackets();
    test_random_traffic(18, 300);
    test_random_traffic(74, 295);
    test_random_traffic(0, 295);

    wait_for_quiet();
    repeat (20) @(posedge clk);
    faults_hit = 0;
    for (int c = ERR_PTR_HIGH; c <= ERR_UNKNOWN; c++) faults_hit += fault_seen[3'(c)];
    $display("Run covered %0d item transfers (%0d steps, %0d loads, %0d restarts)",
             action_count[ACT_STEP] + action_count[ACT_LOAD] +
             action_count[ACT_RESTART] + action_count[ACT_UNUSED],
             action_count[ACT_STEP], action_count[ACT_LOAD], action_count[ACT_RESTART]);
    $display("and compared %0d results; %0d of 5 fault codes were raised.",
             results_checked, faults_hit);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
